FILE: src/zrs_pkg.sv
// Shared types and constants for the zero run splitter.
package zrs_pkg;

  localparam int RUN_W = 32;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int QUEUE_DEPTH = 3;

  // register index in the configuration map
  localparam logic [0:0] REG_MIN_ZERO_RUN = 1'b0;
  localparam logic [15:0] MIN_ZERO_RUN_RESET = 16'd10;

  typedef struct packed {
    logic [RUN_W-1:0] run_length;
    logic             zero_run;
    logic             item_last;
    logic             block_last;
  } run_t;

endpackage

FILE: src/zero_run_splitter.sv
// Zero run splitter: turns a sample block into alternating mixed/zero run lengths.
//
// Input channel (in_valid/in_ready): one signed 16-bit sample per word, with
// block_end marking the last sample of a block. Output channel
// (out_valid/out_ready): one run word per handshake, with zero_run telling an
// all-zero run from a mixed run, item_last on the last run caused by an input
// word and block_last on the final run of the block.
// The run counters are updated in the cycle a sample is accepted and the runs
// it closes (zero to three) are loaded into a three-entry result queue, so a
// run appears on the output in the cycle after the closing sample. A sample that
// closes at most one run keeps the rate at one sample per cycle while the
// receiver is ready; one that closes more runs holds the input while the queue
// drains, one run per cycle through the output port when the receiver is ready.
// A new sample is taken while the last queued run is being handed over, so
// the output register never idles the input. When the receiver stalls, the
// queue holds and in_ready stays low while any run is waiting.
// Reset clears both counters and the queue and sets min_zero_run to 10.
// The APB port holds min_zero_run at byte address 0; change it only while idle.
module zero_run_splitter
  import zrs_pkg::*;
#(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [15:0]    sample,
  input  logic                  block_end,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [RUN_W-1:0]      run_length,
  output logic                  zero_run,
  output logic                  item_last,
  output logic                  block_last
);

  localparam int CW = COUNT_WIDTH;
  localparam int CMP_W = (CW > 16) ? CW : 16;
  localparam logic [CW-1:0] CNT_MAX = '1;

  logic [15:0]   min_zero_run;
  logic [CW-1:0] mixed_count;
  logic [CW-1:0] pending_zeros;
  logic [CW-1:0] mixed_count_next;
  logic [CW-1:0] pending_zeros_next;

  run_t          queue [QUEUE_DEPTH];
  logic [1:0]    fill;
  run_t          res [QUEUE_DEPTH];
  logic [1:0]    res_count;

  logic          in_fire;
  logic          out_fire;
  logic          cfg_write;
  logic          nonzero;
  logic [15:0]   min_eff;
  logic          close_run;
  logic [CW+1:0] mix_sum;
  logic [CW-1:0] mix_sat;
  logic [CW-1:0] pend_inc;

  function automatic run_t make_run(logic [CW-1:0] len, logic is_zero);
    run_t r;
    logic [63:0] wide;
    wide = 64'(len);
    r.run_length = (|wide[63:RUN_W]) ? '1 : wide[RUN_W-1:0];
    r.zero_run   = is_zero;
    r.item_last  = 1'b0;
    r.block_last = 1'b0;
    return r;
  endfunction

  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == REG_MIN_ZERO_RUN) ? CFG_DATA_W'(min_zero_run) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_zero_run <= MIN_ZERO_RUN_RESET;
    end else if (cfg_write && paddr[2] == REG_MIN_ZERO_RUN) begin
      min_zero_run <= pwdata[15:0];
    end
  end

  // handshakes
  assign out_valid = (fill != 2'd0);
  assign out_fire  = out_valid && out_ready;
  assign in_ready  = (fill == 2'd0) || (fill == 2'd1 && out_ready);
  assign in_fire   = in_valid && in_ready;

  assign run_length = queue[0].run_length;
  assign zero_run   = queue[0].zero_run;
  assign item_last  = queue[0].item_last;
  assign block_last = queue[0].block_last;

  // run decisions for the incoming word
  assign nonzero   = |sample;
  assign min_eff   = (min_zero_run == 16'd0) ? 16'd1 : min_zero_run;
  assign close_run = CMP_W'(pending_zeros) >= CMP_W'(min_eff);
  assign mix_sum   = {2'b00, mixed_count} + {2'b00, pending_zeros} + (CW+2)'(1);
  assign mix_sat   = (|mix_sum[CW+1:CW]) ? CNT_MAX : mix_sum[CW-1:0];
  assign pend_inc  = (pending_zeros == CNT_MAX) ? CNT_MAX : pending_zeros + CW'(1);

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      res[i] = '0;
    end
    res_count          = 2'd0;
    mixed_count_next   = mixed_count;
    pending_zeros_next = pending_zeros;

    if (nonzero) begin
      if (close_run) begin
        res[0]           = make_run(mixed_count, 1'b0);
        res[1]           = make_run(pending_zeros, 1'b1);
        res_count        = 2'd2;
        mixed_count_next = CW'(1);
      end else begin
        mixed_count_next = mix_sat;
      end
      pending_zeros_next = '0;
    end else begin
      pending_zeros_next = pend_inc;
    end

    if (block_end) begin
      if (pending_zeros_next != '0) begin
        res[res_count]        = make_run(mixed_count_next, 1'b0);
        res[res_count + 2'd1] = make_run(pending_zeros_next, 1'b1);
        res_count             = res_count + 2'd2;
      end else if (mixed_count_next != '0) begin
        res[res_count] = make_run(mixed_count_next, 1'b0);
        res_count      = res_count + 2'd1;
      end
      if (res_count != 2'd0) begin
        res[res_count - 2'd1].block_last = 1'b1;
      end
      mixed_count_next   = '0;
      pending_zeros_next = '0;
    end

    if (res_count != 2'd0) begin
      res[res_count - 2'd1].item_last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mixed_count   <= '0;
      pending_zeros <= '0;
    end else if (in_fire) begin
      mixed_count   <= mixed_count_next;
      pending_zeros <= pending_zeros_next;
    end
  end

  // result queue: load on accept, shift on each handed-over word
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= 2'd0;
    end else if (in_fire) begin
      fill <= res_count;
    end else if (out_fire) begin
      fill <= fill - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        queue[i] <= res[i];
      end
    end else if (out_fire) begin
      queue[0] <= queue[1];
      queue[1] <= queue[2];
    end
  end

  // checks
  assert property (@(posedge clk) disable iff (rst) fill <= 2'd3)
    else $error("result queue overfilled");

  assert property (@(posedge clk) disable iff (rst)
    (in_fire && block_end) |=> (mixed_count == '0 && pending_zeros == '0))
    else $error("counters not cleared at end of block");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && block_last) |-> item_last)
    else $error("block_last without item_last");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && item_last) |-> (fill == 2'd1))
    else $error("item_last word not at tail of queue");

  assert property (@(posedge clk) disable iff (rst) in_ready |-> (fill <= 2'd1))
    else $error("input accepted over pending runs");

endmodule
